FILE: sv/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

  // Command codes carried on in_cmd.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // Result status codes carried on out_status.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_POS   = 2'd2,
    ST_EMPTY = 2'd3
  } st_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PLACE,
    S_WALK,
    S_WALK_ADV,
    S_INS_COMMIT,
    S_INS_LINK,
    S_DEL_VIC,
    S_DEL_RDV,
    S_DEL_FIN,
    S_EMIT
  } ple_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic scan_clr;
    logic scan_inc;
    logic walk_start;
    logic cur_set_none;
    logic walk_adv;
    logic rd_vic;
    logic vic_from_head;
    logic vic_from_link;
    logic ins_commit;
    logic ins_link_prev;
    logic del_commit;
    logic err_load;
    st_t  err_code;
    logic emit;
  } ple_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       list_empty;
    logic       ins_pos_bad;
    logic       del_pos_bad;
    logic       pos_zero;
    logic       scan_free;
    logic       scan_last;
    logic       walk_done;
    logic       cur_none;
    logic       link_none;
    logic       out_busy;
  } ple_stat_t;

endpackage

FILE: sv/ple_ctrl.sv
// Sequencing state machine of the positional list engine.
module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ple_pkg::ple_stat_t stat,
  output ple_pkg::ple_ctl_t  ctl
);
  import ple_pkg::*;

  ple_state_t state_r;
  ple_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.op == OP_INSERT || stat.op == OP_APPEND) begin
          state_nxt = S_SCAN;
        end else if (stat.op == OP_DELETE) begin
          if (stat.list_empty || stat.del_pos_bad) state_nxt = S_EMIT;
          else if (stat.pos_zero) state_nxt = S_DEL_RDV;
          else state_nxt = S_WALK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        if (stat.scan_free) state_nxt = S_PLACE;
        else if (stat.scan_last) state_nxt = S_EMIT;
      end
      S_PLACE: begin
        if (stat.list_empty) state_nxt = S_INS_COMMIT;
        else if (stat.op == OP_INSERT && stat.ins_pos_bad) state_nxt = S_EMIT;
        else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (!stat.walk_done) begin
          state_nxt = S_WALK_ADV;
        end else if (stat.op == OP_DELETE) begin
          state_nxt = stat.cur_none ? S_EMIT : S_DEL_VIC;
        end else begin
          state_nxt = S_INS_COMMIT;
        end
      end
      S_WALK_ADV:   state_nxt = S_WALK;
      S_INS_COMMIT: state_nxt = stat.cur_none ? S_EMIT : S_INS_LINK;
      S_INS_LINK:   state_nxt = S_EMIT;
      S_DEL_VIC:    state_nxt = stat.link_none ? S_EMIT : S_DEL_RDV;
      S_DEL_RDV:    state_nxt = S_DEL_FIN;
      S_DEL_FIN:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl          = '0;
    ctl.err_code = ST_OK;
    in_stall     = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        ctl.load_in = in_valid;
      end
      S_CHECK: begin
        if (stat.op == OP_INSERT || stat.op == OP_APPEND) begin
          ctl.scan_clr = 1'b1;
        end else if (stat.op == OP_DELETE) begin
          if (stat.list_empty) begin
            ctl.err_load = 1'b1;
            ctl.err_code = ST_EMPTY;
          end else if (stat.del_pos_bad) begin
            ctl.err_load = 1'b1;
            ctl.err_code = ST_POS;
          end else if (stat.pos_zero) begin
            ctl.vic_from_head = 1'b1;
          end else begin
            ctl.walk_start = 1'b1;
          end
        end else begin
          ctl.err_load = 1'b1;
          ctl.err_code = ST_POS;
        end
      end
      S_SCAN: begin
        if (!stat.scan_free) begin
          if (stat.scan_last) begin
            ctl.err_load = 1'b1;
            ctl.err_code = ST_FULL;
          end else begin
            ctl.scan_inc = 1'b1;
          end
        end
      end
      S_PLACE: begin
        if (stat.list_empty) begin
          ctl.cur_set_none = 1'b1;
        end else if (stat.op == OP_INSERT && stat.ins_pos_bad) begin
          ctl.err_load = 1'b1;
          ctl.err_code = ST_POS;
        end else begin
          ctl.walk_start = 1'b1;
        end
      end
      S_WALK: begin
        if (stat.walk_done && stat.op == OP_DELETE && stat.cur_none) begin
          ctl.err_load = 1'b1;
          ctl.err_code = ST_POS;
        end
      end
      S_WALK_ADV: begin
        ctl.walk_adv = 1'b1;
      end
      S_INS_COMMIT: begin
        ctl.ins_commit = 1'b1;
      end
      S_INS_LINK: begin
        ctl.ins_link_prev = 1'b1;
      end
      S_DEL_VIC: begin
        if (stat.link_none) begin
          ctl.err_load = 1'b1;
          ctl.err_code = ST_POS;
        end else begin
          ctl.vic_from_link = 1'b1;
        end
      end
      S_DEL_RDV: begin
        ctl.rd_vic = 1'b1;
      end
      S_DEL_FIN: begin
        ctl.del_commit = 1'b1;
      end
      S_EMIT: begin
        ctl.emit = !stat.out_busy;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

FILE: sv/ple_dp.sv
// Datapath of the positional list engine: node pool, list registers, result register.
module ple_dp #(
  parameter int NODE_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_cmd,
  input  logic [4:0]         in_position,
  input  logic [31:0]        in_item_value,
  input  ple_pkg::ple_ctl_t  ctl,
  output ple_pkg::ple_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_result_value,
  output logic [3:0]         out_slot,
  output logic [4:0]         out_count_after
);
  import ple_pkg::*;

  localparam int SW   = $clog2(NODE_COUNT);
  localparam int LW   = $clog2(NODE_COUNT + 1);
  localparam int CMPW = (LW > 5) ? LW : 5;
  localparam logic [LW-1:0] NONE = LW'(NODE_COUNT);

  // Node pool.
  logic [31:0]   node_value_mem [NODE_COUNT];
  logic [LW-1:0] node_link_mem  [NODE_COUNT];
  logic [31:0]   value_rd_r;
  logic [LW-1:0] link_rd_r;

  logic [NODE_COUNT-1:0] in_use_r;
  logic [LW-1:0]         head_r;
  logic [LW-1:0]         count_r;

  logic [1:0]    cmd_r;
  logic [4:0]    pos_r;
  logic [31:0]   val_r;
  logic [SW-1:0] scan_r;
  logic [LW-1:0] cur_r;
  logic [LW-1:0] steps_r;
  logic [SW-1:0] vic_r;

  st_t           res_status_r;
  logic [31:0]   res_value_r;
  logic [SW-1:0] res_slot_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_value_r;
  logic [3:0]    out_slot_r;
  logic [4:0]    out_count_r;

  logic [4:0]    eff_pos;
  logic [LW-1:0] steps_init;
  logic          cur_none;
  logic [SW-1:0] rd_addr;
  logic          lnk_we;
  logic [SW-1:0] lnk_wa;
  logic [LW-1:0] lnk_wd;

  assign eff_pos  = (pos_r == 5'd0) ? 5'd1 : pos_r;
  assign cur_none = (cur_r >= NONE);
  assign rd_addr  = ctl.rd_vic ? vic_r : cur_r[SW-1:0];

  always_comb begin
    case (cmd_r)
      OP_INSERT: steps_init = LW'(eff_pos - 5'd1);
      OP_APPEND: steps_init = count_r - 1'b1;
      default:   steps_init = LW'(pos_r - 5'd1);
    endcase
  end

  // One link write per cycle: new node, predecessor splice, or unlink.
  always_comb begin
    lnk_we = 1'b0;
    lnk_wa = scan_r;
    lnk_wd = link_rd_r;
    if (ctl.ins_commit) begin
      lnk_we = 1'b1;
      lnk_wa = scan_r;
      lnk_wd = cur_none ? NONE : link_rd_r;
    end else if (ctl.ins_link_prev) begin
      lnk_we = 1'b1;
      lnk_wa = cur_r[SW-1:0];
      lnk_wd = LW'(scan_r);
    end else if (ctl.del_commit && pos_r != 5'd0) begin
      lnk_we = 1'b1;
      lnk_wa = cur_r[SW-1:0];
      lnk_wd = link_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lnk_we) node_link_mem[lnk_wa] <= lnk_wd;
    if (ctl.ins_commit) node_value_mem[scan_r] <= val_r;
    link_rd_r  <= node_link_mem[rd_addr];
    value_rd_r <= node_value_mem[rd_addr];
  end

  // List bookkeeping and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      head_r      <= NONE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.ins_commit) begin
        in_use_r[scan_r] <= 1'b1;
        count_r          <= count_r + 1'b1;
        if (cur_none) head_r <= LW'(scan_r);
      end else if (ctl.del_commit) begin
        in_use_r[vic_r] <= 1'b0;
        count_r         <= count_r - 1'b1;
        if (pos_r == 5'd0) head_r <= link_rd_r;
      end
      if (ctl.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (ctl.scan_clr) scan_r <= '0;
    else if (ctl.scan_inc) scan_r <= scan_r + 1'b1;
    if (ctl.walk_start) begin
      cur_r   <= head_r;
      steps_r <= steps_init;
    end else if (ctl.cur_set_none) begin
      cur_r <= NONE;
    end else if (ctl.walk_adv) begin
      cur_r   <= link_rd_r;
      steps_r <= steps_r - 1'b1;
    end
    if (ctl.vic_from_head) vic_r <= head_r[SW-1:0];
    else if (ctl.vic_from_link) vic_r <= link_rd_r[SW-1:0];
    if (ctl.err_load) begin
      res_status_r <= ctl.err_code;
      res_value_r  <= '0;
      res_slot_r   <= '0;
    end else if (ctl.ins_commit) begin
      res_status_r <= ST_OK;
      res_value_r  <= val_r;
      res_slot_r   <= scan_r;
    end else if (ctl.del_commit) begin
      res_status_r <= ST_OK;
      res_value_r  <= value_rd_r;
      res_slot_r   <= vic_r;
    end
    if (ctl.emit) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_slot_r   <= 4'(res_slot_r);
      out_count_r  <= 5'(count_r);
    end
  end

  assign stat.op          = cmd_r;
  assign stat.list_empty  = (count_r == '0) || (head_r >= NONE);
  assign stat.ins_pos_bad = CMPW'(eff_pos) > CMPW'(count_r);
  assign stat.del_pos_bad = CMPW'(pos_r) >= CMPW'(count_r);
  assign stat.pos_zero    = (pos_r == 5'd0);
  assign stat.scan_free   = !in_use_r[scan_r];
  assign stat.scan_last   = (scan_r == SW'(NODE_COUNT - 1));
  assign stat.walk_done   = (steps_r == '0) || cur_none;
  assign stat.cur_none    = cur_none;
  assign stat.link_none   = (link_rd_r >= NONE);
  assign stat.out_busy    = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_slot         = out_slot_r;
  assign out_count_after  = out_count_r;

`ifndef SYNTHESIS
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (head_r == NONE))
    else $error("head and item count disagree");
  a_use_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == int'(count_r))
    else $error("used flags do not match item count");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !(out_valid_r && out_stall))
    else $error("result loaded over a pending item");
`endif

endmodule

FILE: sv/positional_list_engine.sv
// Positional list engine: singly linked list in a pool of NODE_COUNT nodes.
// Steps: check, then the free-slot scan up to the lowest free index for
//   insert/append, then the link walk, then splice or unlink, then emit.
// Throughput: one item at a time (in_stall is high outside idle), longer while a result stalls;
//   the link walk (one registered read per step) and the free scan set it.
// Reset: synchronous, active low; clears used flags, count, head, output valid and state at once.
module positional_list_engine #(
  parameter int NODE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command item channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_item_value,
  // Result item channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_slot,
  output logic [4:0]  out_count_after
);
  import ple_pkg::*;

  ple_ctl_t  ctl;
  ple_stat_t stat;

  // Sequence each item: scan for a free node, walk the links, splice or unlink.
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Hold the pool, head, count and the result register; the result register
  // lets a new item enter while the previous result still waits.
  ple_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .ctl              (ctl),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_slot         (out_slot),
    .out_count_after  (out_count_after)
  );

endmodule
